// File: hw/rtl/npc_pkg.sv
// Package for the nearest palette colour unit: widths, palette level
// tables, candidate types and small helper functions.
// No dependencies.
package npc_pkg;

    // Palette size and field widths
    localparam int PALETTE_SIZE = 256;
    localparam int LIMIT_W      = 9;
    localparam int IDX_W        = 8;
    localparam int CH_W         = 8;
    localparam int SQ_W         = 16;
    localparam int DIST_W       = 18;
    localparam int SUM1_W       = 10;
    localparam int GP_W         = 19;
    localparam int Q_W          = 20;

    // Palette layout
    localparam int N_LEVEL    = 7;    // six cube levels plus silver
    localparam int N_CUBE_LVL = 6;
    localparam int N_BASE     = 8;    // base entries 1..8; 9..15 repeat 1..7
    localparam int N_BOX      = 3;
    localparam int N_GRAY     = 24;
    localparam int CUBE_BASE  = 16;
    localparam int CUBE_SIZE  = 216;
    localparam int GRAY_BASE  = 232;

    // Minimum tree
    localparam int N_LEAF     = 64;
    localparam int TREE_DEPTH = 6;
    localparam int N_FRONT    = 4;    // stages ahead of the tree
    localparam int N_STAGE    = N_FRONT + TREE_DEPTH;

    // Level codes
    localparam logic [2:0] LVL_00 = 3'd0;
    localparam logic [2:0] LVL_5F = 3'd1;
    localparam logic [2:0] LVL_87 = 3'd2;
    localparam logic [2:0] LVL_AF = 3'd3;
    localparam logic [2:0] LVL_D7 = 3'd4;
    localparam logic [2:0] LVL_FF = 3'd5;
    localparam logic [2:0] LVL_C0 = 3'd6;

    // Register map
    localparam int         CFG_ADDR_W        = 3;
    localparam logic [0:0] REG_PALETTE_LIMIT = 1'b0;

    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
    } cand_t;

    typedef struct packed {
        logic [2:0]      dig;
        logic [SQ_W-1:0] sq;
    } pick_t;

    typedef logic [N_LEVEL-1:0][SQ_W-1:0] sq_row_t;

    // Channel value of a level code
    function automatic logic [CH_W-1:0] level_val(input logic [2:0] code);
        logic [CH_W-1:0] v;
        case (code)
            LVL_00:  v = 8'h00;
            LVL_5F:  v = 8'h5F;
            LVL_87:  v = 8'h87;
            LVL_AF:  v = 8'hAF;
            LVL_D7:  v = 8'hD7;
            LVL_FF:  v = 8'hFF;
            LVL_C0:  v = 8'hC0;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Level code of channel ch (0 red, 1 green, 2 blue) of base entry i (1..8)
    function automatic logic [2:0] base_lvl(input logic [3:0] i, input logic [1:0] ch);
        logic [2:0] code;
        if (i == 4'd8)
            code = LVL_C0;
        else if (i[ch])
            code = LVL_FF;
        else
            code = LVL_00;
        return code;
    endfunction

    // Channel value of gray step k
    function automatic logic [CH_W-1:0] gray_val(input logic [4:0] k);
        return CH_W'(8 + 10 * int'(k));
    endfunction

    // Three times the square of gray step k
    function automatic logic [Q_W-1:0] gray_sq3(input logic [4:0] k);
        return Q_W'(3 * int'(gray_val(k)) * int'(gray_val(k)));
    endfunction

    // Cube index from three digits
    function automatic logic [IDX_W-1:0] cube_idx(input logic [2:0] r,
                                                  input logic [2:0] g,
                                                  input logic [2:0] b);
        return IDX_W'(CUBE_BASE) + IDX_W'(r) * 8'd36 + IDX_W'(g) * 8'd6 + IDX_W'(b);
    endfunction

    // Best of the first len levels, lowest digit on a tie
    function automatic pick_t pick_prefix(input sq_row_t sq, input logic [2:0] len);
        pick_t best;
        best.dig = LVL_00;
        best.sq  = sq[0];
        for (int k = 1; k < N_CUBE_LVL; k++) begin
            if ((3'(k) < len) && (sq[k] < best.sq))
            begin
                best.dig = 3'(k);
                best.sq  = sq[k];
            end
        end
        return best;
    endfunction

    // Pick the right candidate only if strictly closer; left holds lower indexes
    function automatic cand_t cand_min(input cand_t a, input cand_t b);
        cand_t w;
        if (b.vld && (!a.vld || (b.sq_dist < a.sq_dist)))
            w = b;
        else
            w = a;
        return w;
    endfunction

endpackage

// File: hw/rtl/nearest_palette_color_unit.sv
// Nearest palette colour unit: maps an RGB pixel to the closest entry of
// the fixed 256-entry terminal palette. Depends on npc_pkg.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------
//  pixel     | in        | start (busy is always low) | red, green, blue
//  result    | out       | result_valid, one cycle    | color_index
//  config    | in/out    | APB, pready tied high      | paddr, pwdata, prdata
//
// A pixel beat is taken every cycle; its result passes 4 distance stages,
// then a 6-level registered minimum tree over 64 leaves.
// The cube is searched per channel: under the limit it splits into at most
// three boxes, each solved by picking the best level per channel.
// Reset sets palette_limit to 256 and clears the valid chain. Nothing stalls.
module nearest_palette_color_unit
    import npc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // pixel in
    input  logic                  start,
    output logic                  busy,
    input  logic [CH_W-1:0]       red,
    input  logic [CH_W-1:0]       green,
    input  logic [CH_W-1:0]       blue,
    // result out
    output logic                  result_valid,
    output logic [IDX_W-1:0]      color_index
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] palette_limit_reg;
    logic [0:0]         cfg_idx;
    logic               cfg_wr;

    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx == REG_PALETTE_LIMIT) ? 32'(palette_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            palette_limit_reg <= LIMIT_W'(256);
        else if (cfg_wr && (cfg_idx == REG_PALETTE_LIMIT))
            palette_limit_reg <= pwdata[LIMIT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Limit decode (user keeps it static while beats are in flight; unenforced)
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] lim_eff;
    logic [7:0]         cube_lim;
    logic [2:0]         r_len;
    logic [5:0]         r_rem;
    logic [2:0]         g_len;
    logic [2:0]         b_len;

    always_comb
    begin
        if (palette_limit_reg > LIMIT_W'(PALETTE_SIZE))
            lim_eff = LIMIT_W'(PALETTE_SIZE);
        else
            lim_eff = palette_limit_reg;

        if (lim_eff <= LIMIT_W'(CUBE_BASE))
            cube_lim = '0;
        else if (lim_eff >= LIMIT_W'(GRAY_BASE))
            cube_lim = 8'(CUBE_SIZE);
        else
            cube_lim = 8'(lim_eff - LIMIT_W'(CUBE_BASE));

        // full red slabs, then full green rows, then blue cells
        r_len = '0;
        for (int k = 1; k <= N_CUBE_LVL; k++) begin
            if (cube_lim >= 8'(36 * k))
                r_len = r_len + 3'd1;
        end
        r_rem = 6'(cube_lim - 8'(r_len) * 8'd36);
        g_len = '0;
        for (int k = 1; k < N_CUBE_LVL; k++) begin
            if (r_rem >= 6'(6 * k))
                g_len = g_len + 3'd1;
        end
        b_len = 3'(r_rem - 6'(g_len) * 6'd6);
    end

    // ------------------------------------------------------------------
    // Valid chain: the unit never holds a beat off
    // ------------------------------------------------------------------
    logic [N_STAGE-1:0] vld_reg;
    logic [N_STAGE-1:0] vld_next;
    logic               take;

    assign busy     = 1'b0;
    assign take     = start && !busy;
    assign vld_next = {vld_reg[N_STAGE-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: absolute channel differences to every level, channel sum
    // ------------------------------------------------------------------
    logic [N_LEVEL-1:0][CH_W-1:0] dr_reg, dg_reg, db_reg;
    logic [N_LEVEL-1:0][CH_W-1:0] dr_next, dg_next, db_next;
    logic [SUM1_W-1:0]            sum1_reg, sum1_next;

    always_comb
    begin
        for (int k = 0; k < N_LEVEL; k++) begin
            dr_next[k] = (red >= level_val(3'(k))) ? red - level_val(3'(k))
                                                   : level_val(3'(k)) - red;
            dg_next[k] = (green >= level_val(3'(k))) ? green - level_val(3'(k))
                                                     : level_val(3'(k)) - green;
            db_next[k] = (blue >= level_val(3'(k))) ? blue - level_val(3'(k))
                                                    : level_val(3'(k)) - blue;
        end
        sum1_next = SUM1_W'(red) + SUM1_W'(green) + SUM1_W'(blue);
    end

    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        dg_reg   <= dg_next;
        db_reg   <= db_next;
        sum1_reg <= sum1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the differences, gray cross terms 2*v*(r+g+b)
    // ------------------------------------------------------------------
    sq_row_t                      sqr_reg, sqg_reg, sqb_reg;
    sq_row_t                      sqr_next, sqg_next, sqb_next;
    logic [N_GRAY-1:0][GP_W-1:0]  gp_reg, gp_next;

    always_comb
    begin
        for (int k = 0; k < N_LEVEL; k++) begin
            sqr_next[k] = SQ_W'(dr_reg[k]) * SQ_W'(dr_reg[k]);
            sqg_next[k] = SQ_W'(dg_reg[k]) * SQ_W'(dg_reg[k]);
            sqb_next[k] = SQ_W'(db_reg[k]) * SQ_W'(db_reg[k]);
        end
        for (int k = 0; k < N_GRAY; k++)
            gp_next[k] = GP_W'({gray_val(5'(k)), 1'b0}) * GP_W'(sum1_reg);
    end

    always_ff @(posedge clk)
    begin
        sqr_reg <= sqr_next;
        sqg_reg <= sqg_next;
        sqb_reg <= sqb_next;
        gp_reg  <= gp_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: per-channel cube picks, base distances, gray partial terms
    // ------------------------------------------------------------------
    pick_t                         r_pre_reg, g_all_reg, b_all_reg, g_pre_reg, b_pre_reg;
    pick_t                         r_pre_next, g_all_next, b_all_next, g_pre_next, b_pre_next;
    logic [SQ_W-1:0]               sqr_at_reg, sqg_at_reg, sqr_at_next, sqg_at_next;
    logic [N_BASE-1:0][DIST_W-1:0] base_d_reg, base_d_next;
    logic [N_GRAY-1:0][Q_W-1:0]    q_reg, q_next;
    logic [DIST_W-1:0]             s2_reg, s2_next;

    always_comb
    begin
        r_pre_next  = pick_prefix(sqr_reg, r_len);
        g_all_next  = pick_prefix(sqg_reg, 3'(N_CUBE_LVL));
        b_all_next  = pick_prefix(sqb_reg, 3'(N_CUBE_LVL));
        g_pre_next  = pick_prefix(sqg_reg, g_len);
        b_pre_next  = pick_prefix(sqb_reg, b_len);
        sqr_at_next = sqr_reg[r_len];
        sqg_at_next = sqg_reg[g_len];

        for (int i = 0; i < N_BASE; i++) begin
            base_d_next[i] = DIST_W'(sqr_reg[base_lvl(4'(i + 1), 2'd0)])
                           + DIST_W'(sqg_reg[base_lvl(4'(i + 1), 2'd1)])
                           + DIST_W'(sqb_reg[base_lvl(4'(i + 1), 2'd2)]);
        end

        // gray distance = r^2+g^2+b^2 + 3v^2 - 2v(r+g+b); partial term here
        s2_next = DIST_W'(sqr_reg[LVL_00]) + DIST_W'(sqg_reg[LVL_00])
                + DIST_W'(sqb_reg[LVL_00]);
        for (int k = 0; k < N_GRAY; k++)
            q_next[k] = gray_sq3(5'(k)) - Q_W'(gp_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        r_pre_reg  <= r_pre_next;
        g_all_reg  <= g_all_next;
        b_all_reg  <= b_all_next;
        g_pre_reg  <= g_pre_next;
        b_pre_reg  <= b_pre_next;
        sqr_at_reg <= sqr_at_next;
        sqg_at_reg <= sqg_at_next;
        base_d_reg <= base_d_next;
        q_reg      <= q_next;
        s2_reg     <= s2_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: leaves in index order (base, cube boxes, gray)
    // ------------------------------------------------------------------
    cand_t [N_LEAF-1:0] leaf_reg, leaf_next;

    always_comb
    begin
        for (int n = 0; n < N_LEAF; n++)
            leaf_next[n] = '0;

        for (int i = 0; i < N_BASE; i++) begin
            leaf_next[i].vld     = LIMIT_W'(i + 1) < lim_eff;
            leaf_next[i].sq_dist = base_d_reg[i];
            leaf_next[i].idx     = IDX_W'(i + 1);
        end

        // slabs below the partial one
        leaf_next[N_BASE].vld     = r_len != 3'd0;
        leaf_next[N_BASE].sq_dist = DIST_W'(r_pre_reg.sq) + DIST_W'(g_all_reg.sq)
                                  + DIST_W'(b_all_reg.sq);
        leaf_next[N_BASE].idx     = cube_idx(r_pre_reg.dig, g_all_reg.dig, b_all_reg.dig);

        // full rows of the partial slab
        leaf_next[N_BASE + 1].vld     = g_len != 3'd0;
        leaf_next[N_BASE + 1].sq_dist = DIST_W'(sqr_at_reg) + DIST_W'(g_pre_reg.sq)
                                      + DIST_W'(b_all_reg.sq);
        leaf_next[N_BASE + 1].idx     = cube_idx(r_len, g_pre_reg.dig, b_all_reg.dig);

        // partial row of the partial slab
        leaf_next[N_BASE + 2].vld     = b_len != 3'd0;
        leaf_next[N_BASE + 2].sq_dist = DIST_W'(sqr_at_reg) + DIST_W'(sqg_at_reg)
                                      + DIST_W'(b_pre_reg.sq);
        leaf_next[N_BASE + 2].idx     = cube_idx(r_len, g_len, b_pre_reg.dig);

        for (int k = 0; k < N_GRAY; k++) begin
            leaf_next[N_BASE + N_BOX + k].vld     = LIMIT_W'(GRAY_BASE + k) < lim_eff;
            leaf_next[N_BASE + N_BOX + k].sq_dist = DIST_W'(Q_W'(s2_reg) + q_reg[k]);
            leaf_next[N_BASE + N_BOX + k].idx     = IDX_W'(GRAY_BASE + k);
        end
    end

    always_ff @(posedge clk)
    begin
        leaf_reg <= leaf_next;
    end

    // ------------------------------------------------------------------
    // Stages 5..10: registered minimum tree, heap order, node 1 is the root
    // ------------------------------------------------------------------
    cand_t [N_LEAF-1:1] node_reg, node_next;

    always_comb
    begin
        for (int n = 1; n < N_LEAF; n++) begin
            if (2 * n >= N_LEAF)
                node_next[n] = cand_min(leaf_reg[2 * n - N_LEAF], leaf_reg[2 * n + 1 - N_LEAF]);
            else
                node_next[n] = cand_min(node_reg[2 * n], node_reg[2 * n + 1]);
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    assign result_valid = vld_reg[N_STAGE-1];
    assign color_index  = node_reg[1].vld ? node_reg[1].idx : '0;

endmodule
